[hdl/rqss_pkg.sv]
// Shared constants, types and codes for the ring queue with strided sum.
package rqss_pkg;

  localparam int DEPTH    = 1024;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int WORD_W   = 32;
  localparam int FUNC_W   = 2;
  localparam int STRIDE_W = 11;
  localparam int FILL_W   = 11;
  localparam int OFF_W    = ((CNT_W > STRIDE_W) ? CNT_W : STRIDE_W) + 1;

  localparam logic signed [WORD_W-1:0] INT_MIN = {1'b1, {(WORD_W-1){1'b0}}};

  typedef enum logic [FUNC_W-1:0] {
    FN_ENQ = 2'd0,
    FN_DEQ = 2'd1,
    FN_SUM = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEAD,
    ST_HWAIT,
    ST_SUM,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                     we;
    logic [IDX_W-1:0]         waddr;
    logic signed [WORD_W-1:0] wdata;
    logic                     re;
    logic [IDX_W-1:0]         raddr;
  } mem_req_t;

endpackage

[hdl/rqss_if.sv]
// Valid/ready channel interfaces for the queue's operation and result beats.
interface rqss_in_if
  import rqss_pkg::*;
  ;
  logic                       valid;
  logic                       ready;
  logic [FUNC_W-1:0]          func;
  logic signed [WORD_W-1:0]   push_value;
  logic [STRIDE_W-1:0]        stride;

  modport source (output valid, output func, output push_value, output stride, input ready);
  modport sink (input valid, input func, input push_value, input stride, output ready);
endinterface

interface rqss_out_if
  import rqss_pkg::*;
  ;
  logic                       valid;
  logic                       ready;
  logic signed [WORD_W-1:0]   popped_value;
  logic signed [WORD_W-1:0]   head_value;
  logic signed [WORD_W-1:0]   tail_value;
  logic [FILL_W-1:0]          fill_count;
  logic                       is_full;
  logic                       is_empty;
  logic                       rejected;
  logic signed [WORD_W-1:0]   stride_sum;

  modport source (output valid, output popped_value, output head_value, output tail_value,
                  output fill_count, output is_full, output is_empty, output rejected,
                  output stride_sum, input ready);
  modport sink (input valid, input popped_value, input head_value, input tail_value,
                input fill_count, input is_full, input is_empty, input rejected,
                input stride_sum, output ready);
endinterface

[hdl/rqss_store.sv]
// Ring entry store: one write port and one registered read port.
module rqss_store
  import rqss_pkg::*;
(
  input  logic                     clk,
  input  mem_req_t                 req,
  output logic signed [WORD_W-1:0] rd_data
);

  logic signed [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_data <= mem[req.raddr];
    end
  end

endmodule

[hdl/ring_queue_with_strided_sum_core.sv]
// Ring queue of signed words with enqueue, dequeue and strided-sum operations.
//
// The in_chan channel carries one operation per beat (func, push_value,
// stride); the out_chan channel returns exactly one result beat per operation,
// in order, with the popped word, front and rear words, fill count, full,
// empty, rejected and strided sum. One operation is worked on at a time and
// in_chan.ready is high only while the sequencer is idle.
// From acceptance to the result register: enqueue, unused codes and a
// dequeue that leaves the queue empty go straight to the done state; any
// other dequeue first fetches the new front word through the store's single
// read port; strided sum does one store read and one accumulator add per
// visited entry, drains the last read, and the done state loads the result.
// The result register frees the input side: a new beat is accepted while the
// previous result still waits. If the receiver stalls, the next operation
// completes and holds in its final state until the result register is free.
// Synchronous active-low reset empties the queue (front index 0, rear index
// at the last slot) and clears the output valid; store contents are not reset
// and no clearing pass is run.
module ring_queue_with_strided_sum_core
  import rqss_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  rqss_in_if.sink     in_chan,
  rqss_out_if.source  out_chan
);

  state_t state_r, state_nxt;

  logic [IDX_W-1:0]         head_r, head_nxt;
  logic [IDX_W-1:0]         tail_r, tail_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic signed [WORD_W-1:0] head_val_r, head_val_nxt;
  logic signed [WORD_W-1:0] tail_val_r, tail_val_nxt;
  logic [STRIDE_W-1:0]      step_r, step_nxt;
  logic [OFF_W-1:0]         off_r, off_nxt;
  logic [IDX_W-1:0]         ptr_r, ptr_nxt;
  logic                     pend_r, pend_nxt;
  logic signed [WORD_W-1:0] acc_r, acc_nxt;
  logic signed [WORD_W-1:0] popped_r, popped_nxt;
  logic                     rej_r, rej_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic signed [WORD_W-1:0] out_popped_r, out_head_r, out_tail_r, out_sum_r;
  logic [FILL_W-1:0]        out_fill_r;
  logic                     out_full_r, out_empty_r, out_rej_r;

  mem_req_t                 mem_req;
  logic signed [WORD_W-1:0] rd_data;

  logic                     accept;
  logic                     out_free;
  logic                     load_out;
  logic                     walk_more;
  logic [OFF_W-1:0]         ptr_sum;
  logic [IDX_W-1:0]         tail_inc;
  logic [IDX_W-1:0]         head_inc;

  function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] idx);
    return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

  rqss_store u_store (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  assign accept    = in_chan.valid && in_chan.ready;
  assign out_free  = !out_valid_r || out_chan.ready;
  assign load_out  = (state_r == ST_DONE) && out_free;
  assign walk_more = off_r < OFF_W'(count_r);
  assign tail_inc  = idx_next(tail_r);
  assign head_inc  = idx_next(head_r);
  // The walk pointer wraps by one compare and subtract; a step of DEPTH or
  // more always ends the walk before the pointer is used again.
  assign ptr_sum   = OFF_W'(ptr_r) + OFF_W'(step_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (func_t'(in_chan.func))
            FN_DEQ:  state_nxt = (count_r > CNT_W'(1)) ? ST_HEAD : ST_DONE;
            FN_SUM:  state_nxt = ST_SUM;
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_HEAD:  state_nxt = ST_HWAIT;
      ST_HWAIT: state_nxt = ST_DONE;
      ST_SUM:   state_nxt = walk_more ? ST_SUM : ST_DONE;
      ST_DONE:  state_nxt = out_free ? ST_IDLE : ST_DONE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Handshake and store port.
  always_comb begin
    in_chan.ready = (state_r == ST_IDLE);
    mem_req       = '0;
    mem_req.waddr = tail_inc;
    mem_req.wdata = in_chan.push_value;
    mem_req.raddr = (state_r == ST_SUM) ? ptr_r : head_r;
    case (state_r)
      ST_IDLE: mem_req.we = accept && (func_t'(in_chan.func) == FN_ENQ)
                            && (count_r != CNT_W'(DEPTH));
      ST_HEAD: mem_req.re = 1'b1;
      ST_SUM:  mem_req.re = walk_more;
      default: begin
      end
    endcase
  end

  // Queue indexes, shadow words and the strided-sum accumulator.
  always_comb begin
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    count_nxt    = count_r;
    head_val_nxt = head_val_r;
    tail_val_nxt = tail_val_r;
    step_nxt     = step_r;
    off_nxt      = off_r;
    ptr_nxt      = ptr_r;
    pend_nxt     = pend_r;
    acc_nxt      = acc_r;
    popped_nxt   = popped_r;
    rej_nxt      = rej_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          popped_nxt = INT_MIN;
          rej_nxt    = 1'b0;
          acc_nxt    = '0;
          pend_nxt   = 1'b0;
          off_nxt    = '0;
          ptr_nxt    = head_r;
          step_nxt   = (in_chan.stride == '0) ? STRIDE_W'(1) : in_chan.stride;
          case (func_t'(in_chan.func))
            FN_ENQ: begin
              if (count_r == CNT_W'(DEPTH)) begin
                rej_nxt = 1'b1;
              end else begin
                tail_nxt     = tail_inc;
                count_nxt    = count_r + 1'b1;
                tail_val_nxt = in_chan.push_value;
                if (count_r == '0) begin
                  head_val_nxt = in_chan.push_value;
                end
              end
            end
            FN_DEQ: begin
              if (count_r == '0) begin
                rej_nxt = 1'b1;
              end else begin
                popped_nxt = head_val_r;
                head_nxt   = head_inc;
                count_nxt  = count_r - 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_HWAIT: head_val_nxt = rd_data;
      ST_SUM: begin
        // Read data comes from the store's registered port, so the add trails the walk.
        if (pend_r) begin
          acc_nxt = acc_r + rd_data;
        end
        pend_nxt = walk_more;
        if (walk_more) begin
          off_nxt = off_r + OFF_W'(step_r);
          ptr_nxt = (ptr_sum >= OFF_W'(DEPTH)) ? IDX_W'(ptr_sum - OFF_W'(DEPTH))
                                               : IDX_W'(ptr_sum);
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= IDX_W'(DEPTH - 1);
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_val_r <= head_val_nxt;
    tail_val_r <= tail_val_nxt;
    step_r     <= step_nxt;
    off_r      <= off_nxt;
    ptr_r      <= ptr_nxt;
    acc_r      <= acc_nxt;
    popped_r   <= popped_nxt;
    rej_r      <= rej_nxt;
    if (load_out) begin
      out_popped_r <= popped_r;
      out_head_r   <= (count_r == '0) ? INT_MIN : head_val_r;
      out_tail_r   <= (count_r == '0) ? INT_MIN : tail_val_r;
      out_fill_r   <= FILL_W'(count_r);
      out_full_r   <= (count_r == CNT_W'(DEPTH));
      out_empty_r  <= (count_r == '0);
      out_rej_r    <= rej_r;
      out_sum_r    <= acc_r;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.popped_value = out_popped_r;
  assign out_chan.head_value   = out_head_r;
  assign out_chan.tail_value   = out_tail_r;
  assign out_chan.fill_count   = out_fill_r;
  assign out_chan.is_full      = out_full_r;
  assign out_chan.is_empty     = out_empty_r;
  assign out_chan.rejected     = out_rej_r;
  assign out_chan.stride_sum   = out_sum_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count exceeds the queue depth");

  a_write_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.we |=> (count_r == $past(count_r) + 1'b1) && (tail_r == $past(tail_inc)))
    else $error("store write without a matching count and rear index update");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_empty_r) |-> (out_fill_r == '0) && (out_head_r == INT_MIN)
                                     && (out_tail_r == INT_MIN))
    else $error("empty result beat carries stale front or rear words");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SUM && mem_req.re) |-> (off_r < OFF_W'(count_r)))
    else $error("strided walk read past the stored entries");

endmodule
